FILE: rtl/core/qap_pkg.sv
`timescale 1ns / 1ps

package qap_pkg;

    localparam logic [1:0] MODE_LOAD_W = 2'd0;
    localparam logic [1:0] MODE_LOAD_Z = 2'd1;
    localparam logic [1:0] MODE_EVAL   = 2'd2;

    localparam logic [2:0] KIND_OBJ      = 3'd0;
    localparam logic [2:0] KIND_ROW      = 3'd1;
    localparam logic [2:0] KIND_SLACKROW = 3'd2;
    localparam logic [2:0] KIND_COL      = 3'd3;
    localparam logic [2:0] KIND_SLACKCOL = 3'd4;

    localparam logic [3:0] REG_SRC_COUNT = 4'd0;
    localparam logic [3:0] REG_TGT_COUNT = 4'd1;

    localparam logic [15:0] Z_ONE = 16'd32768;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         src_first;
        logic [3:0]         tgt_first;
        logic [2:0]         src_second;
        logic [2:0]         tgt_second;
        logic signed [15:0] pair_weight;
        logic [15:0]        assign_value;
    } t_in;

    typedef struct packed {
        logic signed [63:0] sum_value;
        logic [2:0]         sum_kind;
        logic [2:0]         sum_index;
        logic               last;
    } t_out;

endpackage

FILE: rtl/core/qap_ram.sv
`timescale 1ns / 1ps

module qap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/qap_objective_constraint_eval.sv
`timescale 1ns / 1ps

// Quadratic-assignment objective and constraint evaluator.
// Items enter on the command channel (i_in) with start while busy is low.
// A weight load (mode 0) or assignment load (mode 1) is written in the cycle of
// its transfer and gives no result; the next item may follow at once.
// An evaluate (mode 2) gives m+n+3 results on o_result, one cycle each, marked
// by o_result_strobe, with last set on the final one. Busy stays high for the
// whole run. Its length is set by the single shared multiplier and the one
// read port of each store: each (i,j) pair first reads z(i,j), then each
// weight term with i!=k and j!=l is read, multiplied twice and added while
// skipped terms only step indices; constraint sums read one entry at a time.
// Registers source_count and target_count are written on the cfg channel,
// which is always ready; write them only while the block is idle.
// After reset the weight and assignment stores are cleared, one entry per
// cycle, over max(MAX_SOURCES^2*MAX_TARGETS^2, (MAX_SOURCES+1)*(MAX_TARGETS+1))
// entries (4096 at the default size); busy is high meanwhile.
// The receiver cannot stall: each result is valid for exactly one cycle.
module qap_objective_constraint_eval #(
    parameter int MAX_SOURCES = 8,
    parameter int MAX_TARGETS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  qap_pkg::t_in       i_in,
    output logic               o_result_strobe,
    output qap_pkg::t_out      o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    localparam int MAXN   = (MAX_SOURCES > MAX_TARGETS) ? MAX_SOURCES : MAX_TARGETS;
    localparam int IW     = $clog2(MAXN + 1);
    localparam int WDEPTH = MAX_SOURCES * MAX_TARGETS * MAX_SOURCES * MAX_TARGETS;
    localparam int ZDEPTH = (MAX_SOURCES + 1) * (MAX_TARGETS + 1);
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int ZAW    = $clog2(ZDEPTH);
    localparam int CLR    = (WDEPTH > ZDEPTH) ? WDEPTH : ZDEPTH;
    localparam int CLW    = $clog2(CLR + 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ZPQ   = 4'd2;
    localparam logic [3:0] ST_ZLAT  = 4'd3;
    localparam logic [3:0] ST_TERM  = 4'd4;
    localparam logic [3:0] ST_MUL1  = 4'd5;
    localparam logic [3:0] ST_MUL2  = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_CRD   = 4'd8;
    localparam logic [3:0] ST_CADD  = 4'd9;

    function automatic logic [WAW-1:0] waddr_of(int i, int j, int k, int l);
        return WAW'(((i * MAX_TARGETS + j) * MAX_SOURCES + k) * MAX_TARGETS + l);
    endfunction

    function automatic logic [ZAW-1:0] zaddr_of(int i, int j);
        return ZAW'(i * (MAX_TARGETS + 1) + j);
    endfunction

    function automatic logic [IW-1:0] clamp_count(logic [3:0] v, int maxv);
        if (v == 4'd0) begin
            return IW'(1);
        end
        if (int'(v) > maxv) begin
            return IW'(maxv);
        end
        return IW'(v);
    endfunction

    logic [3:0]         r_state, n_state;
    logic [CLW-1:0]     r_clr, n_clr;
    logic [IW-1:0]      r_m, r_n;
    logic [IW-1:0]      r_p, n_p, r_q, n_q, r_r, n_r, r_s, n_s;
    logic [2:0]         r_kind, n_kind;
    logic [IW-1:0]      r_idx, n_idx, r_cnt, n_cnt;
    logic signed [63:0] r_acc, n_acc;
    logic signed [47:0] r_prod, n_prod;
    logic [15:0]        r_zpq, n_zpq, r_zrs, n_zrs;
    logic               r_strobe, n_strobe;
    qap_pkg::t_out      r_out, n_out;

    logic               accept;
    logic               w_we, z_we;
    logic [WAW-1:0]     w_waddr, w_raddr;
    logic [ZAW-1:0]     z_waddr, z_raddr;
    logic [15:0]        w_wdata, z_wdata, w_rdata, z_rdata;
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    logic               skip, last_s, last_r, last_q, last_p;
    logic               inner_end;
    logic [IW-1:0]      c_row, c_col;
    logic signed [63:0] c_sum;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Store write ports: the clearing sweep after reset, otherwise load items.
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = (int'(r_clr) < WDEPTH);
            w_waddr = WAW'(r_clr);
            w_wdata = 16'd0;
            z_we    = (int'(r_clr) < ZDEPTH);
            z_waddr = ZAW'(r_clr);
            z_wdata = 16'd0;
        end else begin
            w_we = accept && (i_in.mode == qap_pkg::MODE_LOAD_W)
                && (int'(i_in.src_first) < MAX_SOURCES)
                && (int'(i_in.src_second) < MAX_SOURCES)
                && (int'(i_in.tgt_first) < MAX_TARGETS)
                && (int'(i_in.tgt_second) < MAX_TARGETS);
            w_waddr = waddr_of(int'(i_in.src_first), int'(i_in.tgt_first),
                               int'(i_in.src_second), int'(i_in.tgt_second));
            w_wdata = i_in.pair_weight;
            z_we = accept && (i_in.mode == qap_pkg::MODE_LOAD_Z)
                && (int'(i_in.src_first) <= MAX_SOURCES)
                && (int'(i_in.tgt_first) <= MAX_TARGETS);
            z_waddr = zaddr_of(int'(i_in.src_first), int'(i_in.tgt_first));
            z_wdata = (i_in.assign_value > qap_pkg::Z_ONE) ? qap_pkg::Z_ONE
                                                           : i_in.assign_value;
        end
    end

    qap_ram #(.WIDTH(16), .DEPTH(WDEPTH), .AW(WAW)) u_wstore (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    qap_ram #(.WIDTH(16), .DEPTH(ZDEPTH), .AW(ZAW)) u_zstore (
        .i_clk   (i_clk),
        .i_we    (z_we),
        .i_waddr (z_waddr),
        .i_wdata (z_wdata),
        .i_raddr (z_raddr),
        .o_rdata (z_rdata)
    );

    // The one multiplier: weight times z(i,j) first, then that times z(k,l).
    assign mul_a = (r_state == ST_MUL1) ? 32'($signed(w_rdata)) : r_prod[31:0];
    assign mul_b = $signed({1'b0, (r_state == ST_MUL1) ? r_zpq : r_zrs});
    assign mul_p = mul_a * mul_b;

    assign skip   = (r_p == r_r) || (r_q == r_s);
    assign last_s = (r_s == r_n - 1'b1);
    assign last_r = (r_r == r_m - 1'b1);
    assign last_q = (r_q == r_n - 1'b1);
    assign last_p = (r_p == r_m - 1'b1);

    // Entry addressed by the constraint walk and the end of its inner loop.
    always_comb begin
        case (r_kind)
            qap_pkg::KIND_ROW: begin
                c_row     = r_idx;
                c_col     = r_cnt;
                inner_end = (r_cnt == r_n);
            end
            qap_pkg::KIND_SLACKROW: begin
                c_row     = r_m;
                c_col     = r_cnt;
                inner_end = (r_cnt == r_n - 1'b1);
            end
            qap_pkg::KIND_COL: begin
                c_row     = r_cnt;
                c_col     = r_idx;
                inner_end = (r_cnt == r_m);
            end
            default: begin
                c_row     = r_cnt;
                c_col     = r_n;
                inner_end = (r_cnt == r_m - 1'b1);
            end
        endcase
    end

    assign c_sum = r_acc + 64'(z_rdata);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_p      = r_p;
        n_q      = r_q;
        n_r      = r_r;
        n_s      = r_s;
        n_kind   = r_kind;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_zpq    = r_zpq;
        n_zrs    = r_zrs;
        n_strobe = 1'b0;
        n_out    = r_out;
        w_raddr  = waddr_of(int'(r_p), int'(r_q), int'(r_r), int'(r_s));
        z_raddr  = zaddr_of(int'(r_r), int'(r_s));

        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (int'(r_clr) == CLR - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && i_in.mode == qap_pkg::MODE_EVAL) begin
                    n_p     = '0;
                    n_q     = '0;
                    n_r     = '0;
                    n_s     = '0;
                    n_acc   = '0;
                    n_state = ST_ZPQ;
                end
            end
            ST_ZPQ: begin
                z_raddr = zaddr_of(int'(r_p), int'(r_q));
                n_state = ST_ZLAT;
            end
            ST_ZLAT: begin
                n_zpq   = z_rdata;
                n_state = ST_TERM;
            end
            ST_TERM: begin
                if (!skip) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                n_prod  = 48'(mul_p);
                n_zrs   = z_rdata;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_prod  = 48'(mul_p);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                // Terms stay below 2^46 and there are fewer than 2^16 of them,
                // so the sum cannot reach the 64-bit limits.
                n_acc = r_acc + 64'(r_prod);
            end
            ST_CRD: begin
                z_raddr = zaddr_of(int'(c_row), int'(c_col));
                n_state = ST_CADD;
            end
            ST_CADD: begin
                if (inner_end) begin
                    n_strobe            = 1'b1;
                    n_out.sum_value     = c_sum;
                    n_out.sum_kind      = r_kind;
                    n_out.sum_index     = (r_kind == qap_pkg::KIND_ROW
                                           || r_kind == qap_pkg::KIND_COL)
                                          ? 3'(r_idx) : 3'd0;
                    n_out.last          = 1'b0;
                    n_acc               = '0;
                    n_cnt               = '0;
                    n_state             = ST_CRD;
                    case (r_kind)
                        qap_pkg::KIND_ROW: begin
                            if (r_idx == r_m - 1'b1) begin
                                n_kind = qap_pkg::KIND_SLACKROW;
                                n_idx  = '0;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                        qap_pkg::KIND_SLACKROW: begin
                            n_kind = qap_pkg::KIND_COL;
                            n_idx  = '0;
                        end
                        qap_pkg::KIND_COL: begin
                            if (r_idx == r_n - 1'b1) begin
                                n_kind = qap_pkg::KIND_SLACKCOL;
                                n_idx  = '0;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                        default: begin
                            n_out.last = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    endcase
                end else begin
                    n_acc   = c_sum;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_CRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Step the four objective indices after a term is added or skipped.
        if ((r_state == ST_TERM && skip) || r_state == ST_ACC) begin
            if (!last_s) begin
                n_s     = r_s + 1'b1;
                n_state = ST_TERM;
            end else if (!last_r) begin
                n_s     = '0;
                n_r     = r_r + 1'b1;
                n_state = ST_TERM;
            end else if (!last_q) begin
                n_s     = '0;
                n_r     = '0;
                n_q     = r_q + 1'b1;
                n_state = ST_ZPQ;
            end else if (!last_p) begin
                n_s     = '0;
                n_r     = '0;
                n_q     = '0;
                n_p     = r_p + 1'b1;
                n_state = ST_ZPQ;
            end else begin
                n_strobe        = 1'b1;
                n_out.sum_value = n_acc;
                n_out.sum_kind  = qap_pkg::KIND_OBJ;
                n_out.sum_index = 3'd0;
                n_out.last      = 1'b0;
                n_acc           = '0;
                n_kind          = qap_pkg::KIND_ROW;
                n_idx           = '0;
                n_cnt           = '0;
                n_state         = ST_CRD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
            r_m      <= clamp_count(4'd8, MAX_SOURCES);
            r_n      <= clamp_count(4'd8, MAX_TARGETS);
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == qap_pkg::REG_SRC_COUNT) begin
                    r_m <= clamp_count(i_cfg_data, MAX_SOURCES);
                end else if (i_cfg_index == qap_pkg::REG_TGT_COUNT) begin
                    r_n <= clamp_count(i_cfg_data, MAX_TARGETS);
                end
            end
        end
        r_p    <= n_p;
        r_q    <= n_q;
        r_r    <= n_r;
        r_s    <= n_s;
        r_kind <= n_kind;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_zpq  <= n_zpq;
        r_zrs  <= n_zrs;
        r_out  <= n_out;
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_out;

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.last) |-> !busy)
        else $error("final result shown while the block is still busy");

    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !busy) |-> o_result.last)
        else $error("result shown while idle without last");

    a_eval_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.mode == qap_pkg::MODE_EVAL) |=> busy)
        else $error("evaluate transfer did not start a run");

    a_obj_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.sum_kind == qap_pkg::KIND_OBJ)
        |-> (o_result.sum_index == 3'd0 && !o_result.last))
        else $error("objective result carries an index or last");

endmodule
